FILE: rtl/core/ttl_lru_lookup_cache_defines.svh
// Assertion macros used by the checker file tlc_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef TTL_LRU_LOOKUP_CACHE_DEFINES_SVH
`define TTL_LRU_LOOKUP_CACHE_DEFINES_SVH
`define TLC_ASSERT_IMP(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) else $error(msg);
`define TLC_ASSERT_NXT(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/core/tlc_pkg.sv
// Package for the TTL/LRU lookup cache: entry type, commands, constants.
// Depends on nothing.
`default_nettype none
package tlc_pkg;
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_SWEEP  = 2'd2;
  localparam logic [47:0] MS_PER_S = 48'd1000;
  localparam logic [31:0] MAX_TTL_RESET = 32'd86400;
  typedef struct packed {
    logic        valid;
    logic [15:0] qtype;
    logic [15:0] code;
    logic [15:0] count;
    logic [15:0] handle;
    logic [31:0] ttl;
    logic [47:0] ins;
    logic [47:0] lu;
  } entry_t;
endpackage
`default_nettype wire

FILE: rtl/core/ttl_lru_lookup_cache.sv
// One request at a time: a new request is taken only while idle.
// Pass one rotates the entry ring past the head to find match, free slot and LRU;
// pass two rotates again, applies the update at the head and counts occupancy.
// Results cannot be stalled.
// Reset (rst, synchronous): all entries invalid, max TTL 86400 s.
// Depends on tlc_pkg and tlc_cell.
`default_nettype none
module ttl_lru_lookup_cache #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire [1:0]   command,
  input  wire [63:0]  name_key,
  input  wire [15:0]  query_type,
  input  wire [15:0]  response_code,
  input  wire [15:0]  answer_count,
  input  wire [15:0]  answer_handle,
  input  wire [31:0]  ttl_in,
  input  wire [47:0]  now_ms,
  input  wire         cfg_we,
  input  wire [31:0]  cfg_data,
  output logic        done,
  output logic        hit,
  output logic [15:0] hit_response_code,
  output logic [15:0] hit_answer_count,
  output logic [15:0] hit_answer_handle,
  output logic [31:0] hit_ttl,
  output logic [47:0] hit_inserted_at,
  output logic [6:0]  occupied_count
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_P1   = 2'd1;
  localparam logic [1:0] ST_P2   = 2'd2;

  logic [1:0]  state;
  logic [IW-1:0] cnt;
  logic [31:0] max_ttl;
  logic [1:0]  cmd;
  logic [KEY_WIDTH-1:0] key;
  tlc_pkg::entry_t new_e;
  logic [47:0] now;
  logic match_found, free_found, exp_flag;
  logic [IW-1:0] match_idx, free_idx, best_idx;
  logic [47:0] best_lu;
  tlc_pkg::entry_t cap_e;
  logic [CW-1:0] occ;

  tlc_pkg::entry_t ring_q [CAPACITY];
  logic [KEY_WIDTH-1:0] ring_k [CAPACITY];
  tlc_pkg::entry_t head, tail;
  logic [KEY_WIDTH-1:0] head_key;
  logic shift, head_exp, head_match;
  logic [47:0] life;
  logic [IW-1:0] target;
  logic [31:0] ttl_cl;

  assign head     = ring_q[0];
  assign head_key = ring_k[0];
  assign shift    = (state == ST_P1) || (state == ST_P2);
  assign busy     = (state != ST_IDLE);
  assign life     = {16'd0, head.ttl} * tlc_pkg::MS_PER_S;
  assign head_exp = (now < head.ins) || ((now - head.ins) >= life);
  assign head_match = head.valid && (head.qtype == new_e.qtype) && (head_key == key);
  assign target = match_found ? match_idx : (free_found ? free_idx : best_idx);
  assign ttl_cl = (ttl_in == 32'd0) ? 32'd1 : ((ttl_in > max_ttl) ? max_ttl : ttl_in);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_ring
    tlc_pkg::entry_t      dd;
    logic [KEY_WIDTH-1:0] dk;
    if (i == CAPACITY - 1) begin : g_tail
      assign dd = tail;
      assign dk = (state == ST_P2 && cmd == tlc_pkg::CMD_INSERT && cnt == target)
                  ? key : head_key;
    end else begin : g_mid
      assign dd = ring_q[i+1];
      assign dk = ring_k[i+1];
    end
    tlc_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk(clk), .rst(rst), .shift(shift),
      .d(dd), .d_key(dk), .q(ring_q[i]), .q_key(ring_k[i])
    );
  end

  always_comb begin
    tail = head;
    if (state == ST_P2) begin
      case (cmd)
        tlc_pkg::CMD_LOOKUP: begin
          if (match_found && cnt == match_idx) begin
            if (exp_flag) begin
              tail.valid = 1'b0;
            end else begin
              tail.lu = now;
            end
          end
        end
        tlc_pkg::CMD_INSERT: begin
          if (cnt == target) begin
            tail = new_e;
          end
        end
        tlc_pkg::CMD_SWEEP: begin
          if (head.valid && head_exp) begin
            tail.valid = 1'b0;
          end
        end
        default: tail = head;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (cfg_we) begin
      max_ttl <= cfg_data;
    end
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd   <= command;
          key   <= name_key[KEY_WIDTH-1:0];
          now   <= now_ms;
          new_e <= '{valid: 1'b1, qtype: query_type, code: response_code,
                     count: answer_count, handle: answer_handle, ttl: ttl_cl,
                     ins: now_ms, lu: now_ms};
          match_found <= 1'b0;
          free_found  <= 1'b0;
          cnt   <= '0;
          state <= ST_P1;
        end
      end
      ST_P1: begin
        if (head_match && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= cnt;
          exp_flag    <= head_exp;
          cap_e       <= head;
        end
        if (!head.valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cnt;
        end
        if (cnt == '0 || head.lu < best_lu) begin
          best_lu  <= head.lu;
          best_idx <= cnt;
        end
        occ <= '0;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          cnt   <= '0;
          state <= ST_P2;
        end
      end
      ST_P2: begin
        occ <= occ + CW'(tail.valid);
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          state <= ST_IDLE;
          done  <= 1'b1;
          occupied_count <= 7'(occ + CW'(tail.valid));
          hit <= 1'b0;
          hit_response_code <= '0;
          hit_answer_count  <= '0;
          hit_answer_handle <= '0;
          hit_ttl           <= '0;
          hit_inserted_at   <= '0;
          if (cmd == tlc_pkg::CMD_LOOKUP && match_found && !exp_flag) begin
            hit <= 1'b1;
            hit_response_code <= cap_e.code;
            hit_answer_count  <= cap_e.count;
            hit_answer_handle <= cap_e.handle;
            hit_ttl           <= cap_e.ttl;
            hit_inserted_at   <= cap_e.ins;
          end
        end
      end
      default: state <= ST_IDLE;
    endcase
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      max_ttl <= tlc_pkg::MAX_TTL_RESET;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/tlc_cell.sv
// One cache entry of the rotating ring; shifts to its neighbor when enabled.
// Depends on tlc_pkg.
`default_nettype none
module tlc_cell #(
  parameter int KEY_WIDTH = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  shift,
  input  tlc_pkg::entry_t      d,
  input  wire [KEY_WIDTH-1:0]  d_key,
  output tlc_pkg::entry_t      q,
  output logic [KEY_WIDTH-1:0] q_key
);
  always_ff @(posedge clk) begin
    if (shift) begin
      q     <= d;
      q_key <= d_key;
    end
    if (rst) begin
      q.valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/tlc_checker.sv
// Port-level checks of the lookup cache and the bind that attaches them.
// Depends on ttl_lru_lookup_cache_defines.svh and ttl_lru_lookup_cache.
`default_nettype none
`include "ttl_lru_lookup_cache_defines.svh"
module tlc_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire        hit,
  input wire [31:0] hit_ttl,
  input wire [47:0] hit_inserted_at
);
  `TLC_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "request not taken")
  `TLC_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "done while busy")
  `TLC_ASSERT_NXT(a_done_single, clk, rst, done, !done, "done repeated")
  `TLC_ASSERT_IMP(a_miss_zero, clk, rst, done && !hit,
                  hit_ttl == 32'd0 && hit_inserted_at == 48'd0, "miss fields not zero")
endmodule
bind ttl_lru_lookup_cache tlc_checker u_tlc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .hit(hit),
  .hit_ttl(hit_ttl), .hit_inserted_at(hit_inserted_at)
);
`default_nettype wire

FILE: test/tb_ttl_lru_lookup_cache.sv
// Testbench for ttl_lru_lookup_cache: random and directed cache requests checked
// against a behavioral cache model kept in the bench. Depends on tlc_pkg and the RTL.
`timescale 1ns / 1ps
module tb_ttl_lru_lookup_cache;

  localparam int DEPTH = 64;
  localparam int LATENCY = 2 * DEPTH + 1;
  localparam int WATCHDOG = 20000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  command;
    logic [63:0] name_key;
    logic [15:0] query_type;
    logic [15:0] response_code;
    logic [15:0] answer_count;
    logic [15:0] answer_handle;
    logic [31:0] ttl_in;
    logic [47:0] now_ms;
    bit          cfg;
    logic [31:0] cfg_value;
    bit          drain;
  } request_t;

  typedef struct {
    logic        hit;
    logic [15:0] code;
    logic [15:0] count;
    logic [15:0] handle;
    logic [31:0] ttl;
    logic [47:0] ins;
    logic [6:0]  occ;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] command = 0;
  logic [63:0] name_key = 0;
  logic [15:0] query_type = 0, response_code = 0, answer_count = 0, answer_handle = 0;
  logic [31:0] ttl_in = 0;
  logic [47:0] now_ms = 0;
  logic cfg_we = 0;
  logic [31:0] cfg_data = 0;
  logic busy, done, hit;
  logic [15:0] hit_response_code, hit_answer_count, hit_answer_handle;
  logic [31:0] hit_ttl;
  logic [47:0] hit_inserted_at;
  logic [6:0] occupied_count;

  ttl_lru_lookup_cache u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .name_key(name_key), .query_type(query_type), .response_code(response_code),
    .answer_count(answer_count), .answer_handle(answer_handle), .ttl_in(ttl_in),
    .now_ms(now_ms), .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .hit(hit),
    .hit_response_code(hit_response_code), .hit_answer_count(hit_answer_count),
    .hit_answer_handle(hit_answer_handle), .hit_ttl(hit_ttl),
    .hit_inserted_at(hit_inserted_at), .occupied_count(occupied_count)
  );

  always #4 clk = ~clk;

  // cache model state
  logic [31:0] m_max_ttl = tlc_pkg::MAX_TTL_RESET;
  bit          m_valid [DEPTH];
  logic [63:0] m_key [DEPTH];
  logic [15:0] m_type [DEPTH], m_code [DEPTH], m_count [DEPTH], m_handle [DEPTH];
  logic [31:0] m_ttl [DEPTH];
  logic [47:0] m_ins [DEPTH], m_lu [DEPTH];

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int failures = 0;
  int idle_cycles = 0;
  bit stimulus_done = 0;
  logic [47:0] clock_ms = 0;
  logic [63:0] key_pool [16];
  logic [15:0] type_pool [4];

  function automatic bit is_stale(int i, logic [47:0] now);
    logic [63:0] age_limit;
    age_limit = 64'(m_ttl[i]) * 64'd1000;
    if (now < m_ins[i]) return 1;
    return 64'(now - m_ins[i]) >= age_limit;
  endfunction

  function automatic int find_entry(logic [63:0] k, logic [15:0] t);
    for (int i = 0; i < DEPTH; i++)
      if (m_valid[i] && m_type[i] == t && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int pick_victim();
    int best;
    best = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!m_valid[i]) return i;
      if (m_lu[i] < m_lu[best]) best = i;
    end
    return best;
  endfunction

  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int s;
    int n;
    a = '{default: 0};
    if (r.command == tlc_pkg::CMD_LOOKUP) begin
      s = find_entry(r.name_key, r.query_type);
      if (s >= 0) begin
        if (is_stale(s, r.now_ms)) m_valid[s] = 0;
        else begin
          m_lu[s] = r.now_ms;
          a.hit = 1; a.code = m_code[s]; a.count = m_count[s];
          a.handle = m_handle[s]; a.ttl = m_ttl[s]; a.ins = m_ins[s];
        end
      end
    end else if (r.command == tlc_pkg::CMD_INSERT) begin
      s = find_entry(r.name_key, r.query_type);
      if (s < 0) s = pick_victim();
      m_key[s] = r.name_key; m_type[s] = r.query_type; m_code[s] = r.response_code;
      m_count[s] = r.answer_count; m_handle[s] = r.answer_handle;
      if (r.ttl_in == 0) m_ttl[s] = 1;
      else if (r.ttl_in > m_max_ttl) m_ttl[s] = m_max_ttl;
      else m_ttl[s] = r.ttl_in;
      m_ins[s] = r.now_ms; m_lu[s] = r.now_ms; m_valid[s] = 1;
    end else if (r.command == tlc_pkg::CMD_SWEEP) begin
      for (int i = 0; i < DEPTH; i++)
        if (m_valid[i] && is_stale(i, r.now_ms)) m_valid[i] = 0;
    end
    n = 0;
    for (int i = 0; i < DEPTH; i++) n += m_valid[i];
    a.occ = 7'(n);
    return a;
  endfunction

  function automatic request_t make_op(logic [1:0] c, int pool_hit, logic [31:0] ttl,
                                       int step_max);
    request_t r;
    r = '{default: 0};
    r.command = c;
    if (pool_hit != 0) begin
      r.name_key = key_pool[$urandom_range(15)];
      r.query_type = type_pool[$urandom_range(3)];
    end else begin
      r.name_key = {$urandom, $urandom};
      r.query_type = 16'($urandom);
    end
    r.response_code = 16'($urandom);
    r.answer_count = 16'($urandom);
    r.answer_handle = 16'($urandom);
    r.ttl_in = ttl;
    clock_ms += 48'($urandom_range(step_max));
    r.now_ms = clock_ms;
    return r;
  endfunction

  function automatic void push_config(logic [31:0] v);
    request_t r;
    r = '{default: 0};
    r.cfg = 1;
    r.cfg_value = v;
    pending_requests.push_back(r);
  endfunction

  function automatic void push_drain();
    request_t r;
    r = '{default: 0};
    r.drain = 1;
    pending_requests.push_back(r);
  endfunction

  initial begin
    request_t r;
    logic [31:0] ttl;
    int kind;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    type_pool[0] = '0; type_pool[1] = '1; type_pool[2] = 16'd1; type_pool[3] = 16'd28;
    // directed: extremes, clamp, expiry, time going backwards, unused command
    r = make_op(tlc_pkg::CMD_LOOKUP, 0, 0, 0); r.name_key = '0; r.query_type = '0;
    pending_requests.push_back(r);
    r = make_op(tlc_pkg::CMD_INSERT, 0, 0, 0); r.name_key = '0; r.query_type = '0;
    pending_requests.push_back(r);
    r = make_op(tlc_pkg::CMD_INSERT, 0, '1, 0); r.name_key = '1; r.query_type = '1;
    r.response_code = '1; r.answer_count = '1; r.answer_handle = '1;
    pending_requests.push_back(r);
    r = make_op(tlc_pkg::CMD_LOOKUP, 0, 0, 0); r.name_key = '1; r.query_type = '1;
    pending_requests.push_back(r);
    r = make_op(tlc_pkg::CMD_LOOKUP, 0, 0, 1000); r.name_key = '0; r.query_type = '0;
    r.now_ms = clock_ms + 999; pending_requests.push_back(r);
    r.now_ms = clock_ms + 1000; pending_requests.push_back(r);
    r = make_op(tlc_pkg::CMD_INSERT, 0, 5, 0); r.name_key = 64'h55;
    pending_requests.push_back(r);
    r.command = tlc_pkg::CMD_LOOKUP; r.now_ms = clock_ms - 1; pending_requests.push_back(r);
    r.command = CMD_UNUSED; pending_requests.push_back(r);
    r.command = tlc_pkg::CMD_SWEEP; r.now_ms = '1; pending_requests.push_back(r);
    push_drain();
    push_config(0);
    r = make_op(tlc_pkg::CMD_INSERT, 1, 0, 0); pending_requests.push_back(r);
    r = make_op(tlc_pkg::CMD_INSERT, 1, 7, 0); pending_requests.push_back(r);
    r.command = tlc_pkg::CMD_LOOKUP; pending_requests.push_back(r);
    r = make_op(tlc_pkg::CMD_SWEEP, 1, 0, 0); pending_requests.push_back(r);
    push_drain();
    push_config('1);
    r = make_op(tlc_pkg::CMD_INSERT, 0, '1, 0); r.now_ms = '1; pending_requests.push_back(r);
    r.command = tlc_pkg::CMD_LOOKUP; pending_requests.push_back(r);
    r.command = tlc_pkg::CMD_SWEEP; r.now_ms = '0; pending_requests.push_back(r);
    push_drain();
    clock_ms = 0;
    push_config(tlc_pkg::MAX_TTL_RESET);
    // random phases with several clamp settings
    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 205; k++) begin
        kind = $urandom_range(99);
        ttl = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(30));
        if (kind < 45)
          r = make_op(tlc_pkg::CMD_LOOKUP, $urandom_range(9) != 0, 0, 3000);
        else if (kind < 85)
          r = make_op(tlc_pkg::CMD_INSERT, $urandom_range(4) != 0, ttl, 3000);
        else if (kind < 95) r = make_op(tlc_pkg::CMD_SWEEP, 1, 0, 3000);
        else r = make_op(CMD_UNUSED, 0, 0, 3000);
        if ($urandom_range(49) == 0) r.now_ms = {$urandom, 16'($urandom)};
        if ($urandom_range(49) == 0) begin
          clock_ms = {$urandom, 16'($urandom)} >> $urandom_range(40);
          r.now_ms = clock_ms;
        end
        pending_requests.push_back(r);
      end
      push_drain();
      case (ph)
        0: push_config(1);
        1: push_config(32'($urandom_range(2, 40)));
        2: push_config(0);
        3: push_config('1);
        4: push_config($urandom);
        5: push_config(32'd10);
        default: push_config(32'($urandom_range(1, 100)));
      endcase
    end
    stimulus_done = 1;
  end

  // driver
  int gap = 0;
  int drain_wait = 0;
  bit in_flight = 0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
      cfg_we <= 0;
    end else if (start && !busy && !in_flight) begin
      in_flight <= 1;
    end else begin
      cfg_we <= 0;
      if (start && busy) begin
        start <= 0;
        in_flight <= 0;
      end else if (!start && gap > 0) begin
        gap <= gap - 1;
      end else if (!start && !busy && pending_requests.size() > 0) begin
        if (pending_requests[0].drain) begin
          if (expected_answers.size() != 0) drain_wait <= 0;
          else if (drain_wait < LATENCY) drain_wait <= drain_wait + 1;
          else begin
            drain_wait <= 0;
            void'(pending_requests.pop_front());
          end
        end else if (pending_requests[0].cfg) begin
          cfg_we <= 1;
          cfg_data <= pending_requests[0].cfg_value;
          m_max_ttl = pending_requests[0].cfg_value;
          void'(pending_requests.pop_front());
        end else begin
          start <= 1;
          command <= pending_requests[0].command;
          name_key <= pending_requests[0].name_key;
          query_type <= pending_requests[0].query_type;
          response_code <= pending_requests[0].response_code;
          answer_count <= pending_requests[0].answer_count;
          answer_handle <= pending_requests[0].answer_handle;
          ttl_in <= pending_requests[0].ttl_in;
          now_ms <= pending_requests[0].now_ms;
          expected_answers.push_back(apply_request(pending_requests.pop_front()));
          gap <= ($urandom_range(9) == 0) ? $urandom_range(300)
               : ($urandom_range(2) == 0 ? 0 : $urandom_range(4));
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t e;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: request result with none expected", $time);
          failures++;
        end else begin
          e = expected_answers.pop_front();
          if ({hit, hit_response_code, hit_answer_count, hit_answer_handle, hit_ttl,
               hit_inserted_at, occupied_count} !==
              {e.hit, e.code, e.count, e.handle, e.ttl, e.ins, e.occ}) begin
            $display("%0t: expected hit=%0d code=%h cnt=%h hdl=%h ttl=%h ins=%h occ=%0d",
                     $time, e.hit, e.code, e.count, e.handle, e.ttl, e.ins, e.occ);
            $display("%0t: actual   hit=%0d code=%h cnt=%h hdl=%h ttl=%h ins=%h occ=%0d",
                     $time, hit, hit_response_code, hit_answer_count, hit_answer_handle,
                     hit_ttl, hit_inserted_at, occupied_count);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst = 0;
    forever begin
      @(posedge clk);
      if (idle_cycles > WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else if (stimulus_done && pending_requests.size() == 0 && !start &&
                   expected_answers.size() == 0) begin
        repeat (LATENCY + 4) @(posedge clk);
        if (failures == 0 && expected_answers.size() == 0)
          $display("SCOREBOARD CLEAN");
        else
          $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/tlc_pkg.sv
rtl/core/tlc_cell.sv
rtl/core/ttl_lru_lookup_cache.sv
rtl/core/tlc_checker.sv
test/tb_ttl_lru_lookup_cache.sv
